FILE: src/escaped_rle_slide_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escaped run-length decoder core.
// Each macro expands to one labeled concurrent assertion on clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_RLE_SLIDE_DECODER_CORE_ASSERT_SVH
`define ESCAPED_RLE_SLIDE_DECODER_CORE_ASSERT_SVH

`define ERSD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ERSD_ASSERT_ALWAYS(lbl, cond, msg) \
	`ERSD_ASSERT_IMPL(lbl, 1'b1, cond, msg)

`endif

FILE: src/ersd_pkg.sv
// ----------------------------------------------------------------------------
// Escaped run-length decoder package
// Buffer size, escape codes, decoder phases and the item types of both channels.
// ----------------------------------------------------------------------------
package ersd_pkg;

	localparam int unsigned BUFFER_BYTES = 896;
	localparam int unsigned POS_W        = 10;

	localparam logic [7:0] CODE_END = 8'hFF;
	localparam logic [7:0] CODE_RUN = 8'hFE;

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_DECODE,
		PH_RUN_LEN,
		PH_RUN_FILL,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       stream_start;
	} stream_item_t;

	typedef struct packed {
		logic [POS_W-1:0] write_position;
		logic [7:0]       write_value;
		logic [7:0]       write_count;
		logic             record_done;
	} write_item_t;

endpackage

FILE: src/escaped_rle_slide_decoder_core.sv
// ----------------------------------------------------------------------------
// Escaped run-length slide decoder core
// Skips to the selected record of an escape-coded byte stream and turns its
// literals and runs into buffer write descriptors.
// ----------------------------------------------------------------------------
// Encoded bytes enter on the stream channel (valid/ready) and write descriptors
// leave on the write channel (valid/ready). A descriptor passes through the input
// register and then the result register before it is offered. One byte is
// taken every cycle as long as the result register is empty or is being
// emptied in the same cycle; the decoder state is updated in that single pass,
// so there is no further pipelining.
// Bytes that produce no descriptor (skipped records, run headers, zero-length
// runs, bytes after the record) still pass through the input register.
// The record to decode is set by writing cfg_write_data with cfg_write_en;
// the write takes effect at once and should be made while the core is idle.
// Reset clears the decoder to the start of a stream and the record index to
// zero. A byte flagged stream_start restarts skipping and decoding. When the
// receiver stalls, the pending descriptor holds and the core stops taking
// bytes once its input register is also full.
// ----------------------------------------------------------------------------
module escaped_rle_slide_decoder_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  stream_valid,
	output logic                  stream_ready,
	input  ersd_pkg::stream_item_t stream_item,
	output logic                  write_valid,
	input  logic                  write_ready,
	output ersd_pkg::write_item_t write_desc,
	input  logic                  cfg_write_en,
	input  logic [7:0]            cfg_write_data
);
	import ersd_pkg::*;

	logic                 valid_s1;
	stream_item_t         item_s1;
	logic                 valid_s2;
	write_item_t          desc_s2;
	logic [7:0]           record_index_q;
	phase_t               phase_q;
	logic [7:0]           skipped_q;
	logic [POS_W-1:0]     fill_q;
	logic [7:0]           run_len_q;

	logic                 advance;
	phase_t               raw_phase;
	phase_t               cur_phase;
	logic [7:0]           cur_skipped;
	logic [POS_W-1:0]     cur_fill;
	logic [7:0]           cur_run_len;
	logic [POS_W:0]       space;
	logic [POS_W:0]       run_cnt;
	logic [POS_W:0]       lit_end;
	logic [POS_W:0]       run_end;
	logic                 lit_done;
	logic                 run_done;

	phase_t               phase_d;
	logic [7:0]           skipped_d;
	logic [POS_W-1:0]     fill_d;
	logic [7:0]           run_len_d;
	logic                 emit;
	write_item_t          desc_d;

	assign advance      = valid_s1 && (!valid_s2 || write_ready);
	assign stream_ready = !valid_s1 || advance;
	assign write_valid  = valid_s2;
	assign write_desc   = desc_s2;

	always_comb begin
		raw_phase   = item_s1.stream_start ? PH_SKIP : phase_q;
		cur_skipped = item_s1.stream_start ? 8'd0 : skipped_q;
		cur_fill    = item_s1.stream_start ? '0 : fill_q;
		cur_run_len = item_s1.stream_start ? 8'd0 : run_len_q;
		cur_phase   = raw_phase;
		if (raw_phase == PH_SKIP && cur_skipped == record_index_q) begin
			cur_phase = PH_DECODE;
		end
		space    = (POS_W+1)'(BUFFER_BYTES) - {1'b0, cur_fill};
		run_cnt  = ({3'b000, cur_run_len} < space) ? {3'b000, cur_run_len} : space;
		lit_end  = {1'b0, cur_fill} + (POS_W+1)'(1);
		run_end  = {1'b0, cur_fill} + run_cnt;
		lit_done = lit_end >= (POS_W+1)'(BUFFER_BYTES);
		run_done = run_end >= (POS_W+1)'(BUFFER_BYTES);
	end

	always_comb begin
		phase_d   = cur_phase;
		skipped_d = cur_skipped;
		fill_d    = cur_fill;
		run_len_d = cur_run_len;
		case (cur_phase)
			PH_SKIP: begin
				if (item_s1.stream_byte == CODE_END) begin
					skipped_d = cur_skipped + 8'd1;
				end
			end
			PH_DECODE: begin
				if (item_s1.stream_byte == CODE_END) begin
					phase_d = PH_DONE;
				end else if (item_s1.stream_byte == CODE_RUN) begin
					phase_d = PH_RUN_LEN;
				end else begin
					fill_d = lit_end[POS_W-1:0];
					if (lit_done) begin
						phase_d = PH_DONE;
					end
				end
			end
			PH_RUN_LEN: begin
				run_len_d = item_s1.stream_byte;
				phase_d   = PH_RUN_FILL;
			end
			PH_RUN_FILL: begin
				phase_d = PH_DECODE;
				if (run_cnt != '0) begin
					fill_d = run_end[POS_W-1:0];
					if (run_done) begin
						phase_d = PH_DONE;
					end
				end
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
	end

	always_comb begin
		emit                  = 1'b0;
		desc_d.write_position = cur_fill;
		desc_d.write_value    = item_s1.stream_byte;
		desc_d.write_count    = 8'd1;
		desc_d.record_done    = 1'b0;
		case (cur_phase)
			PH_DECODE: begin
				if (item_s1.stream_byte == CODE_END) begin
					emit               = 1'b1;
					desc_d.write_value = 8'd0;
					desc_d.write_count = 8'd0;
					desc_d.record_done = 1'b1;
				end else if (item_s1.stream_byte != CODE_RUN) begin
					emit               = 1'b1;
					desc_d.record_done = lit_done;
				end
			end
			PH_RUN_FILL: begin
				emit               = run_cnt != '0;
				desc_d.write_count = run_cnt[7:0];
				desc_d.record_done = run_done;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream_ready) begin
			valid_s1 <= stream_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream_ready && stream_valid) begin
			item_s1 <= stream_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= emit;
		end else if (write_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			desc_s2 <= desc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SKIP;
			skipped_q <= 8'd0;
			fill_q    <= '0;
			run_len_q <= 8'd0;
		end else if (advance) begin
			phase_q   <= phase_d;
			skipped_q <= skipped_d;
			fill_q    <= fill_d;
			run_len_q <= run_len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_index_q <= 8'd0;
		end else if (cfg_write_en) begin
			record_index_q <= cfg_write_data;
		end
	end

`include "escaped_rle_slide_decoder_core_assert.svh"

	`ERSD_ASSERT_ALWAYS(a_fill_in_range, fill_q <= POS_W'(BUFFER_BYTES), "fill position beyond buffer")
	`ERSD_ASSERT_IMPL(a_done_phase, write_valid && write_desc.record_done, phase_q == PH_DONE, "record done without done phase")
	`ERSD_ASSERT_IMPL(a_zero_count_ends, write_valid && write_desc.write_count == 8'd0, write_desc.record_done, "zero count descriptor not ending record")

endmodule

FILE: tb/tb_escaped_rle_slide_decoder_core.sv
// ----------------------------------------------------------------------------
// Testbench for the escaped run-length slide decoder core
// Feeds escape-coded byte streams through the stream channel, predicts the
// buffer write descriptors in a behavioral decoder and compares every
// descriptor on the write channel. Directed cases cover record skipping,
// runs, end markers, buffer clipping and restarts; random streams follow
// under varied record indexes, sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_escaped_rle_slide_decoder_core;
	import ersd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS = 700;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES  = 200;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         stream_valid = 1'b0;
	logic         stream_ready;
	stream_item_t stream_item = '0;
	logic         write_valid;
	logic         write_ready = 1'b0;
	write_item_t  write_desc;
	logic         cfg_write_en = 1'b0;
	logic [7:0]   cfg_write_data = 8'h00;

	// Decoder state as predicted from the accepted items.
	phase_t      dec_phase;
	logic [7:0]  dec_skipped;
	int unsigned dec_fill_pos;
	logic [7:0]  dec_run_len;
	logic [7:0]  dec_record_index;

	write_item_t writes_due[$];

	int unsigned items_sent;
	int unsigned writes_checked;
	int unsigned index_writes;
	int unsigned errors;
	int unsigned burst_left;
	bit          tx_gaps_on;
	bit          start_pending;
	int unsigned rx_mode;
	int unsigned rx_hold_left;
	int unsigned rx_tick;

	escaped_rle_slide_decoder_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.stream_valid   (stream_valid),
		.stream_ready   (stream_ready),
		.stream_item    (stream_item),
		.write_valid    (write_valid),
		.write_ready    (write_ready),
		.write_desc     (write_desc),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data)
	);

	always #6 clk = ~clk;

	function automatic void restart_decoder();
		dec_phase    = PH_SKIP;
		dec_skipped  = 8'h00;
		dec_fill_pos = 0;
		dec_run_len  = 8'h00;
	endfunction

	function automatic bit decode_byte(input logic [7:0] code, input logic first,
			output write_item_t w);
		int unsigned space;
		int unsigned cnt;
		bit          last;
		w = '0;
		if (first)
			restart_decoder();
		if (dec_phase == PH_SKIP) begin
			if (dec_skipped == dec_record_index) begin
				dec_phase = PH_DECODE;
			end else begin
				if (code == CODE_END)
					dec_skipped = dec_skipped + 8'd1;
				return 1'b0;
			end
		end
		case (dec_phase)
			PH_DECODE: begin
				if (code == CODE_END) begin
					w = '{write_position: dec_fill_pos[POS_W-1:0], write_value: 8'h00,
						write_count: 8'h00, record_done: 1'b1};
					dec_phase = PH_DONE;
					return 1'b1;
				end
				if (code == CODE_RUN) begin
					dec_phase = PH_RUN_LEN;
					return 1'b0;
				end
				last = (dec_fill_pos + 1) >= BUFFER_BYTES;
				w = '{write_position: dec_fill_pos[POS_W-1:0], write_value: code,
					write_count: 8'd1, record_done: last};
				dec_fill_pos++;
				if (last)
					dec_phase = PH_DONE;
				return 1'b1;
			end
			PH_RUN_LEN: begin
				dec_run_len = code;
				dec_phase = PH_RUN_FILL;
				return 1'b0;
			end
			PH_RUN_FILL: begin
				dec_phase = PH_DECODE;
				space = (dec_fill_pos < BUFFER_BYTES) ? BUFFER_BYTES - dec_fill_pos : 0;
				cnt = (dec_run_len < space) ? dec_run_len : space;
				if (cnt == 0)
					return 1'b0;
				last = (dec_fill_pos + cnt) >= BUFFER_BYTES;
				w = '{write_position: dec_fill_pos[POS_W-1:0], write_value: code,
					write_count: cnt[7:0], record_done: last};
				dec_fill_pos += cnt;
				if (last)
					dec_phase = PH_DONE;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk) begin
		write_item_t got_w;
		write_item_t exp_w;
		write_item_t new_w;
		if (arst_n) begin
			if (write_valid && write_ready) begin
				got_w = write_desc;
				writes_checked++;
				if (writes_due.size() == 0) begin
					errors++;
					$display("%0t: descriptor with none expected: pos %0d value %0d count %0d done %0d",
						$time, got_w.write_position, got_w.write_value, got_w.write_count,
						got_w.record_done);
				end else begin
					exp_w = writes_due.pop_front();
					if (exp_w !== got_w) begin
						errors++;
						if (exp_w.write_position !== got_w.write_position)
							$display("%0t: write_position expected %0d, got %0d", $time,
								exp_w.write_position, got_w.write_position);
						if (exp_w.write_value !== got_w.write_value)
							$display("%0t: write_value expected %0d, got %0d", $time,
								exp_w.write_value, got_w.write_value);
						if (exp_w.write_count !== got_w.write_count)
							$display("%0t: write_count expected %0d, got %0d", $time,
								exp_w.write_count, got_w.write_count);
						if (exp_w.record_done !== got_w.record_done)
							$display("%0t: record_done expected %0d, got %0d", $time,
								exp_w.record_done, got_w.record_done);
					end
				end
			end
			if (stream_valid && stream_ready) begin
				if (decode_byte(stream_item.stream_byte, stream_item.stream_start, new_w))
					writes_due.push_back(new_w);
			end
		end
	end

	always @(negedge clk) begin
		rx_tick++;
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			write_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: write_ready <= 1'b1;
				1: write_ready <= ($urandom_range(0, 1) == 1);
				2: write_ready <= ($urandom_range(0, 7) != 0);
				3: write_ready <= ((rx_tick % 5) < 3);
				default: write_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic send_byte(input logic [7:0] code, input logic first);
		int unsigned gap;
		if (tx_gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = $urandom_range(1, 6);
			@(negedge clk);
			stream_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		stream_valid <= 1'b1;
		stream_item <= '{stream_byte: code, stream_start: first};
		if (burst_left > 0)
			burst_left--;
		items_sent++;
		do @(posedge clk); while (!stream_ready);
	endtask

	task automatic send_coded(input logic [7:0] code);
		send_byte(code, start_pending);
		start_pending = 1'b0;
	endtask

	task automatic send_bytes(input logic [7:0] codes[$], input bit first);
		start_pending = first;
		foreach (codes[i])
			send_coded(codes[i]);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		stream_valid <= 1'b0;
		while (writes_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_record_index(input logic [7:0] value);
		wait_idle();
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		dec_record_index = value;
		index_writes++;
	endtask

	task automatic send_record(input int unsigned tokens, input bit terminated);
		int unsigned pick;
		int unsigned len;
		repeat (tokens) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_coded(8'($urandom_range(0, 253)));
			end else if (pick < 92) begin
				send_coded(CODE_RUN);
				len = $urandom_range(0, 9);
				if (len == 0)
					send_coded(8'h00);
				else if (len == 1)
					send_coded(8'($urandom_range(128, 255)));
				else
					send_coded(8'($urandom_range(1, 16)));
				send_coded(8'($urandom_range(0, 255)));
			end else begin
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
			end
		end
		if (terminated)
			send_coded(CODE_END);
	endtask

	task automatic send_stream();
		int unsigned records;
		start_pending = ($urandom_range(0, 9) != 0);
		records = dec_record_index + $urandom_range(1, 2);
		repeat (records)
			send_record($urandom_range(0, 10), $urandom_range(0, 9) != 0);
	endtask

	task automatic test_default_record();
		send_bytes('{8'h00, 8'hFD, 8'h7F, 8'h80, CODE_RUN, 8'h03, 8'hAA, CODE_RUN, 8'h00,
			8'h55, CODE_RUN, CODE_RUN, 8'h01, CODE_END, 8'h12, CODE_RUN}, 1'b0);
	endtask

	task automatic test_record_skip();
		set_record_index(8'd2);
		send_bytes('{8'h01, CODE_END, 8'h02, CODE_RUN, 8'h10, 8'h20, CODE_END,
			CODE_RUN, 8'hFF, 8'hFF, 8'h44, CODE_END}, 1'b1);
	endtask

	task automatic test_index_change_midstream();
		set_record_index(8'd3);
		send_bytes('{8'h01, CODE_END}, 1'b1);
		set_record_index(8'd1);
		send_bytes('{8'h09, CODE_END}, 1'b0);
	endtask

	task automatic test_restart_midrecord();
		set_record_index(8'd0);
		send_bytes('{8'h05, 8'h06, CODE_RUN, 8'h04}, 1'b1);
		send_bytes('{8'h07, CODE_END}, 1'b1);
	endtask

	task automatic test_buffer_clip();
		send_bytes('{CODE_RUN, 8'hFF, 8'h11, CODE_RUN, 8'hFF, 8'h11, CODE_RUN, 8'hFF, 8'h11,
			CODE_RUN, 8'hFF, 8'h22, 8'h55}, 1'b1);
	endtask

	task automatic test_buffer_full_literal();
		send_bytes('{CODE_RUN, 8'hFF, 8'h01, CODE_RUN, 8'hFF, 8'h02, CODE_RUN, 8'hFF, 8'h03,
			CODE_RUN, 8'h82, 8'h04, 8'h33, CODE_RUN}, 1'b1);
	endtask

	task automatic test_max_record_index();
		set_record_index(8'd255);
		start_pending = 1'b1;
		repeat (255)
			send_coded(CODE_END);
		send_bytes('{8'h5A, CODE_END}, 1'b0);
	endtask

	task automatic test_receiver_holdoff();
		set_record_index(8'd0);
		tx_gaps_on = 1'b0;
		rx_mode = 0;
		rx_hold_left = HOLD_CYCLES;
		start_pending = 1'b1;
		repeat (80)
			send_coded(8'($urandom_range(0, 253)));
		send_coded(CODE_END);
	endtask

	task automatic test_random_streams(input int unsigned target);
		int unsigned pick;
		while (items_sent < target) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				set_record_index(8'($urandom_range(7, 15)));
			else if (pick < 12)
				set_record_index(8'($urandom_range(0, 1)));
			else
				set_record_index(8'($urandom_range(2, 6)));
			rx_mode = $urandom_range(0, 4);
			tx_gaps_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 3))
				send_stream();
		end
	endtask

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		dec_record_index = 8'h00;
		restart_decoder();
		tx_gaps_on = 1'b1;
		rx_mode = 1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_record();
		test_record_skip();
		test_index_change_midstream();
		test_restart_midrecord();
		test_buffer_clip();
		test_buffer_full_literal();
		test_max_record_index();
		test_receiver_holdoff();
		test_random_streams(items_sent + RANDOM_ITEMS);
		wait_idle();

		$display("Covered %0d stream items and %0d write descriptors over %0d record index settings,",
			items_sent, writes_checked, index_writes);
		$display("with skipping, runs, clipping at the buffer end, restarts and receiver hold-offs.");
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
